// ----- design/stereo_dc_highpass_soft_gate_top_defines.svh -----
// Assertion macros used by the checker of the stereo DC blocker / gate.
// No dependencies.
`ifndef STEREO_DC_HIGHPASS_SOFT_GATE_TOP_DEFINES_SVH
`define STEREO_DC_HIGHPASS_SOFT_GATE_TOP_DEFINES_SVH

// Antecedent at one edge, consequent at the next, ignored while in reset.
`define SDCHG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold on the edge after reset is seen.
`define SDCHG_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- design/sdchg_pkg.sv -----
// Package for the stereo DC blocker, high-pass and soft gate.
// Fixed-point constants, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdchg_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FRAC_BITS    = 16;
  localparam int DC_COEF      = 8389;   // 0.0005 in Q0.24
  localparam int DC_COEF_BITS = 14;
  localparam int DC_SHIFT     = 24;

  localparam int COEF_W    = 16;
  localparam int THR_W     = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HP_COEF  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THR = 1'b1;

  localparam logic [COEF_W-1:0] HP_COEF_RESET  = 16'd64857;
  localparam logic [THR_W-1:0]  GATE_THR_RESET = 15'd164;

  localparam int PROD_W  = 64;
  localparam int SQ_BITS = THR_W + FRAC_BITS;   // gated magnitude bound
  localparam int DIV_W   = 2 * THR_W + 1;

endpackage

`default_nettype wire

// ----- design/stereo_dc_highpass_soft_gate_top.sv -----
// Stereo DC blocker, one-pole high-pass and soft noise gate, bit-serial datapath.
// Depends on sdchg_pkg.
//
// Usage:
//   Input channel in_valid / in_stall carries one word: a stereo frame
//   left_in, right_in. A word is taken when in_valid is high and in_stall low.
//   Output channel out_valid / out_stall returns one word per frame,
//   left_out, right_out, taken when out_valid is high and out_stall low.
//   cfg_write with cfg_index / cfg_data sets the pole coefficient (index 0)
//   or the gate threshold (index 1); write only while no frame is in flight.
//   Channels are worked one after the other through one shift-add multiplier
//   (one multiplier bit per cycle) and one restoring divider (one quotient bit
//   per cycle); squaring and divide run only when the gate scales a channel.
//   A frame is taken only while the block is idle, never before the last
//   one is done. A finished word sits in the output register while the next
//   frame is accepted and worked; if the receiver still stalls when that
//   frame is done, the block holds it and keeps in_stall high.
//   Synchronous reset clears the filter state, restores the register reset
//   values and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module stereo_dc_highpass_soft_gate_top #(
  parameter int SAMPLE_BITS = sdchg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  input  wire logic                          cfg_write,
  input  wire logic [sdchg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdchg_pkg::COEF_W-1:0]  cfg_data
);

  import sdchg_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int XW  = SB + FRAC_BITS;   // sample in Q.16, DC level
  localparam int CW  = SB + 17;          // centred input
  localparam int FW  = SB + 18;          // filter state
  localparam int SW  = SB + 20;          // filter sum
  localparam int QW  = (SB + 2 > THR_W) ? SB + 2 : THR_W;
  localparam int CNW = $clog2(SQ_BITS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DC_SET   = 4'd1;
  localparam logic [3:0] S_DC_MUL   = 4'd2;
  localparam logic [3:0] S_FILT_SET = 4'd3;
  localparam logic [3:0] S_SUM      = 4'd4;
  localparam logic [3:0] S_HP_MUL   = 4'd5;
  localparam logic [3:0] S_CLAMP    = 4'd6;
  localparam logic [3:0] S_GATE     = 4'd7;
  localparam logic [3:0] S_SQ_MUL   = 4'd8;
  localparam logic [3:0] S_DIV_SET  = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_SAT      = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic signed [PROD_W-1:0] Y_MAX = (PROD_W'(1) <<< (FW - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] Y_MIN = -Y_MAX - PROD_W'(1);
  localparam logic [QW-1:0] Q_POS_MAX = QW'((1 << (SB - 1)) - 1);
  localparam logic [QW-1:0] Q_NEG_MAX = QW'(1 << (SB - 1));
  localparam logic [SB-1:0] OUT_MAX   = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0] OUT_MIN   = {1'b1, {(SB - 1){1'b0}}};

  // control and architectural state
  logic [3:0]            state;
  logic                  ch;
  logic [CNW-1:0]        cnt;
  logic [COEF_W-1:0]     hp_coef;
  logic [THR_W-1:0]      gate_thr;
  logic signed [XW-1:0]  dc [2];
  logic signed [CW-1:0]  cprev [2];
  logic signed [FW-1:0]  yprev [2];

  // datapath
  logic signed [PROD_W-1:0] mcand;
  logic [SQ_BITS-1:0]       mplier;
  logic signed [PROD_W-1:0] acc;
  logic [DIV_W-1:0]         divw;
  logic signed [SB-1:0]     smp [2];
  logic signed [CW-1:0]     c_cur;
  logic signed [FW-1:0]     y_cur;
  logic [QW-1:0]            q;
  logic signed [SB-1:0]     res [2];

  logic signed [XW-1:0]     x_cur;
  logic signed [CW-1:0]     dc_diff;
  logic signed [XW-1:0]     dc_new;
  logic signed [CW-1:0]     c_new;
  logic signed [SW-1:0]     hp_sum;
  logic signed [PROD_W-1:0] y_full;
  logic signed [FW-1:0]     y_clamped;
  logic [FW-1:0]            mag;
  logic [SQ_BITS-1:0]       thr_fix;
  logic                     gated;
  logic [THR_W:0]           rem_try;
  logic                     rem_ge;
  logic [THR_W:0]           rem_new;
  logic signed [SB-1:0]     sat_out;
  logic                     mul_last;
  logic                     out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign mul_last = (cnt == '0);

  always_comb begin
    x_cur   = {smp[ch], {FRAC_BITS{1'b0}}};
    dc_diff = CW'(x_cur) - CW'(dc[ch]);
    dc_new  = dc[ch] + XW'(acc >>> DC_SHIFT);
    c_new   = CW'(x_cur) - CW'(dc_new);
    hp_sum  = SW'(yprev[ch]) + SW'(c_cur) - SW'(cprev[ch]);
    y_full  = acc >>> FRAC_BITS;
    if (y_full > Y_MAX) begin
      y_clamped = Y_MAX[FW-1:0];
    end else if (y_full < Y_MIN) begin
      y_clamped = Y_MIN[FW-1:0];
    end else begin
      y_clamped = y_full[FW-1:0];
    end
    mag     = y_cur[FW-1] ? (~y_cur + FW'(1)) : y_cur;
    thr_fix = {gate_thr, {FRAC_BITS{1'b0}}};
    gated   = PROD_W'(mag) < PROD_W'(thr_fix);
    rem_try = {divw[DIV_W-2:THR_W], divw[THR_W-1]};
    rem_ge  = rem_try >= {1'b0, gate_thr};
    rem_new = rem_ge ? (rem_try - {1'b0, gate_thr}) : rem_try;
    if (!y_cur[FW-1]) begin
      sat_out = (q > Q_POS_MAX) ? OUT_MAX : SB'(q);
    end else begin
      sat_out = (q > Q_NEG_MAX) ? OUT_MIN : SB'(~q + QW'(1));
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_coef  <= HP_COEF_RESET;
      gate_thr <= GATE_THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HP_COEF:  hp_coef  <= cfg_data;
        REG_GATE_THR: gate_thr <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        dc[i]    <= '0;
        cprev[i] <= '0;
        yprev[i] <= '0;
      end
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch    <= 1'b0;
            state <= S_DC_SET;
          end
        end
        S_DC_SET: begin
          cnt   <= CNW'(DC_COEF_BITS - 1);
          state <= S_DC_MUL;
        end
        S_DC_MUL: begin
          cnt <= cnt - CNW'(1);
          if (mul_last) begin
            state <= S_FILT_SET;
          end
        end
        S_FILT_SET: begin
          dc[ch] <= dc_new;
          state  <= S_SUM;
        end
        S_SUM: begin
          cprev[ch] <= c_cur;
          cnt       <= CNW'(COEF_W - 1);
          state     <= S_HP_MUL;
        end
        S_HP_MUL: begin
          cnt <= cnt - CNW'(1);
          if (mul_last) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          yprev[ch] <= y_clamped;
          state     <= S_GATE;
        end
        S_GATE: begin
          if (gated) begin
            cnt   <= CNW'(SQ_BITS - 1);
            state <= S_SQ_MUL;
          end else begin
            state <= S_SAT;
          end
        end
        S_SQ_MUL: begin
          cnt <= cnt - CNW'(1);
          if (mul_last) begin
            state <= S_DIV_SET;
          end
        end
        S_DIV_SET: begin
          cnt   <= CNW'(THR_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - CNW'(1);
          if (mul_last) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (!ch) begin
            ch    <= 1'b1;
            state <= S_DC_SET;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          smp[0] <= left_in;
          smp[1] <= right_in;
        end
      end
      S_DC_SET: begin
        mcand  <= PROD_W'(dc_diff);
        mplier <= SQ_BITS'(DC_COEF);
        acc    <= '0;
      end
      S_DC_MUL, S_HP_MUL, S_SQ_MUL: begin
        acc    <= acc + (mplier[0] ? mcand : '0);
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
      S_FILT_SET: begin
        c_cur <= c_new;
      end
      S_SUM: begin
        mcand  <= PROD_W'(hp_sum);
        mplier <= SQ_BITS'(hp_coef);
        acc    <= '0;
      end
      S_CLAMP: begin
        y_cur <= y_clamped;
      end
      S_GATE: begin
        if (gated) begin
          mcand  <= $signed(PROD_W'(mag));
          mplier <= SQ_BITS'(mag);
          acc    <= '0;
        end else begin
          q <= QW'(mag >> FRAC_BITS);
        end
      end
      S_DIV_SET: begin
        divw <= {1'b0, acc[2 * FRAC_BITS +: 2 * THR_W]};
      end
      S_DIV: begin
        divw <= {rem_new, divw[THR_W-2:0], rem_ge};
        if (mul_last) begin
          q <= QW'({divw[THR_W-2:0], rem_ge});
        end
      end
      S_SAT: begin
        res[ch] <= sat_out;
      end
      S_DONE: begin
        if (out_free) begin
          left_out  <= res[0];
          right_out <= res[1];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/sdchg_checker.sv -----
// Port-level checker for the stereo DC blocker / gate, bound to the top level.
// Depends on sdchg_pkg and stereo_dc_highpass_soft_gate_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_dc_highpass_soft_gate_top_defines.svh"

module sdchg_checker #(
  parameter int SAMPLE_BITS = sdchg_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] left_out,
  input wire logic [SAMPLE_BITS-1:0] right_out
);

  import sdchg_pkg::*;

  // one frame at a time: taking a word closes the input
  `SDCHG_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "input open after take")
  `SDCHG_ASSERT_AFTER_RESET(a_reset_idle, clk, rst, !in_stall && !out_valid, "not idle after reset")
  `SDCHG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "output word dropped")
  `SDCHG_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(left_out) && $stable(right_out), "stalled word changed")

endmodule

bind stereo_dc_highpass_soft_gate_top sdchg_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sdchg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_out  (left_out),
  .right_out (right_out)
);

`default_nettype wire

// ----- bench/tb_stereo_dc_highpass_soft_gate_top.sv -----
// Self-checking bench for stereo_dc_highpass_soft_gate_top: stereo frames in, filtered words out.
// A bit-exact predictor queues the expected words and they are compared in order.
// Depends on sdchg_pkg and the block itself.
`timescale 1ns / 1ps

module tb_stereo_dc_highpass_soft_gate_top;
  import sdchg_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam longint HP_MAX = (longint'(1) <<< (SB + 17)) - 1;
  localparam longint HP_MIN = -HP_MAX - 1;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } stereo_frame_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SB-1:0] left_in;
  logic signed [SB-1:0] right_in;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SB-1:0] left_out;
  logic signed [SB-1:0] right_out;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // predictor state: filter history one entry per channel, plus register copies
  longint            dc_track [2];
  longint            last_centered [2];
  longint            last_highpass [2];
  logic [COEF_W-1:0] pole_coef;
  logic [THR_W-1:0]  gate_level;

  stereo_frame_t expected_frames [$];
  int            mismatch_count = 0;
  bit            no_idle = 0;

  stereo_dc_highpass_soft_gate_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_stereo_dc_highpass_soft_gate_top: done, errors");
    $finish;
  end

  function automatic logic signed [SB-1:0] filter_channel(input int ch,
                                                          input logic signed [SB-1:0] sample);
    longint x, c, sum, y, res;
    longint unsigned m, t, q;
    x = longint'(sample) * (longint'(1) <<< FRAC_BITS);
    dc_track[ch] += ((x - dc_track[ch]) * longint'(DC_COEF)) >>> DC_SHIFT;
    c = x - dc_track[ch];
    sum = last_highpass[ch] + c - last_centered[ch];
    y = (sum * longint'(pole_coef)) >>> FRAC_BITS;
    if (y > HP_MAX) y = HP_MAX;
    if (y < HP_MIN) y = HP_MIN;
    last_centered[ch] = c;
    last_highpass[ch] = y;
    m = (y < 0) ? -y : y;
    t = longint'(gate_level);
    t = t << FRAC_BITS;
    // soft gate: below threshold the magnitude is scaled by m / T
    q = (m < t) ? (m * m) / (t << FRAC_BITS) : m >> FRAC_BITS;
    res = (y < 0) ? -longint'(q) : longint'(q);
    if (res > SAMPLE_MAX) res = SAMPLE_MAX;
    if (res < SAMPLE_MIN) res = SAMPLE_MIN;
    return res[SB-1:0];
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // receiver back-pressure
  initial begin : receiver_stall
    bit stalling;
    int hold;
    stalling = 0;
    hold = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        stalling = !stalling && ($urandom_range(0, 1) == 1);
        hold = stalling ? idle_length() - 1 : $urandom_range(0, 15);
      end
      if (no_idle) stalling = 0;
      out_stall <= stalling;
    end
  end

  always @(posedge clk) begin : check_output
    stereo_frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected word left_out %0d right_out %0d", $time, left_out, right_out);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (left_out !== want.left) begin
          $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out);
          mismatch_count++;
        end
        if (right_out !== want.right) begin
          $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    int gap;
    stereo_frame_t fr;
    gap = (no_idle || $urandom_range(0, 1) == 1) ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    left_in  <= l;
    right_in <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fr.left  = filter_channel(0, l);
    fr.right = filter_channel(1, r);
    expected_frames.push_back(fr);
  endtask

  task automatic wait_until_idle(input int settle);
    @(negedge clk);
    in_valid <= 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 0;
    if (idx == REG_HP_COEF) pole_coef = value;
    else if (idx == REG_GATE_THR) gate_level = value[THR_W-1:0];
  endtask

  // mostly audio-like random walks with DC offset, noise, extremes; or full-scale squares
  task automatic random_frames(input int count, input bit square);
    int walk [2];
    int kind, amp;
    logic signed [SB-1:0] s [2];
    walk[0] = int'($urandom_range(0, 20000)) - 10000;
    walk[1] = int'($urandom_range(0, 20000)) - 10000;
    for (int i = 0; i < count; i++) begin
      for (int ch = 0; ch < 2; ch++) begin
        kind = $urandom_range(0, 99);
        amp = (kind < 35) ? 40 : 2500;
        walk[ch] += int'($urandom_range(0, 2 * amp)) - amp;
        if (walk[ch] > 32767) walk[ch] = 32767;
        if (walk[ch] < -32768) walk[ch] = -32768;
        if (square) s[ch] = ((i / 4) % 2 == ch) ? 16'sh7fff : 16'sh8000;
        else if (kind < 60) s[ch] = SB'(walk[ch]);
        else if (kind < 80) s[ch] = SB'($urandom_range(0, 65535));
        else if (kind < 90) begin
          case ($urandom_range(0, 3))
            0: s[ch] = 16'sh7fff;
            1: s[ch] = 16'sh8000;
            2: s[ch] = '0;
            default: s[ch] = '1;
          endcase
        end else s[ch] = SB'(int'($urandom_range(0, 400)) - 200);
      end
      send_frame(s[0], s[1]);
    end
  endtask

  task automatic test_directed_extremes();
    int lseq [24] = '{0, 32767, -32768, 32767, -32768, 0, 1, -1, 164, -164, 163, -165,
                      16384, -16384, 21845, -21846, 1000, 1000, 1000, -1000,
                      32767, 32767, -32768, 0};
    int rseq [24] = '{0, -32768, 32767, 32767, -32768, 0, -1, 1, -164, 164, 500, -500,
                      -16384, 16384, -21846, 21845, -300, 300, 0, 0,
                      -32768, -32768, 32767, 0};
    for (int i = 0; i < 24; i++) send_frame(SB'(lseq[i]), SB'(rseq[i]));
  endtask

  task automatic test_default_settings();
    random_frames(80, 0);
    wait_until_idle(8);
    no_idle = 1;
    random_frames(60, 0);
    no_idle = 0;
    random_frames(80, 0);
    wait_until_idle(8);
  endtask

  task automatic test_zero_coefficient();
    write_register(REG_HP_COEF, 16'h0000);
    write_register(REG_GATE_THR, 16'h0001);
    random_frames(60, 0);
    wait_until_idle(8);
  endtask

  // coefficient at maximum leans on the state clamp; zero threshold disables the gate
  task automatic test_full_coefficient_open_gate();
    write_register(REG_HP_COEF, 16'hffff);
    write_register(REG_GATE_THR, 16'h8000);
    random_frames(80, 1);
    random_frames(80, 0);
    wait_until_idle(8);
  endtask

  task automatic test_widest_gate();
    write_register(REG_HP_COEF, COEF_W'($urandom_range(0, 65535)));
    write_register(REG_GATE_THR, 16'h7fff);
    random_frames(100, 0);
    wait_until_idle(8);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 4; k++) begin
      write_register(REG_HP_COEF,
                     (k == 0) ? HP_COEF_RESET : COEF_W'($urandom_range(0, 65535)));
      write_register(REG_GATE_THR,
                     (k == 1) ? 16'h0000 : COEF_W'($urandom_range(0, 65535)));
      random_frames(100, 0);
      wait_until_idle(8);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    left_in = 0;
    right_in = 0;
    cfg_write = 0;
    cfg_index = REG_HP_COEF;
    cfg_data = 0;
    pole_coef = HP_COEF_RESET;
    gate_level = GATE_THR_RESET;
    for (int ch = 0; ch < 2; ch++) begin
      dc_track[ch] = 0;
      last_centered[ch] = 0;
      last_highpass[ch] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    test_directed_extremes();
    test_default_settings();
    test_zero_coefficient();
    test_full_coefficient_open_gate();
    test_widest_gate();
    test_random_settings();

    wait_until_idle(170);
    if (mismatch_count == 0)
      $display("tb_stereo_dc_highpass_soft_gate_top: done, clean");
    else
      $display("tb_stereo_dc_highpass_soft_gate_top: done, errors");
    $finish;
  end

endmodule
